// ===== design/pc_pkg.sv =====
// ----------------------------------------------------------------------------
// Peak centroiding package
// Shared types and constants for the centroiding controller and datapath.
// ----------------------------------------------------------------------------
package pc_pkg;

  localparam int unsigned MzW    = 32;
  localparam int unsigned IntW   = 24;
  localparam int unsigned WsumW  = 64;
  localparam int unsigned IsumW  = 32;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned DivCntW = 6;

  localparam logic [0:0] RegNoiseFloor = 1'b0;
  localparam logic [0:0] RegGapLimit   = 1'b1;

  localparam logic [IntW-1:0] NoiseFloorRst = '0;
  localparam logic [MzW-1:0]  GapLimitRst   = 32'd6554;

  typedef struct packed {
    logic [MzW-1:0]  peak_mz;
    logic [IntW-1:0] peak_intensity;
    logic            end_of_spectrum;
  } pc_in_t;

  typedef struct packed {
    logic [MzW-1:0]   centroid_mz;
    logic [IsumW-1:0] centroid_intensity;
    logic             centroid_valid;
    logic             last_result;
  } pc_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FLUSH,
    S_DIV,
    S_EMIT
  } pc_state_e;

  typedef struct packed {
    logic capture;
    logic check;
    logic flush;
    logic div_step;
  } pc_cmd_t;

  typedef struct packed {
    logic close;
    logic eos;
    logic grp_open;
    logic div_last;
    logic res_last;
  } pc_stat_t;

endpackage

// ===== design/peak_centroiding.sv =====
// ----------------------------------------------------------------------------
// Peak centroiding
// Gap-based centroiding of one spectrum's peaks into weighted-mean m/z words.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                   Payload
// in       input      in_valid_i / in_ready_o     pc_in_t  in_word_i
// out      output     out_valid_o / out_ready_i   pc_out_t out_word_o
// cfg      input      cfg_we_i                    cfg_idx_i, cfg_wdata_i
//
// A peak is taken in S_IDLE, the only state with in_ready_o high, and tested
// in S_CHECK; one that closes a group then divides in S_DIV and is emitted
// in S_EMIT. The end word passes S_FLUSH, then S_DIV if a group is open,
// then S_EMIT. The 64-step restoring divider sets the per-centroid latency.
// Reset clears all group state; output stalls hold the block in place.
// ----------------------------------------------------------------------------
module peak_centroiding import pc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [0:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pc_in_t          in_word_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pc_out_t         out_word_o
);

  pc_cmd_t  cmd;
  pc_stat_t stat;

  pc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o)
  );

  pc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== design/pc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Peak centroiding controller
// Sequences capture, accumulation, division and result hand-off per word.
// ----------------------------------------------------------------------------
module pc_ctrl import pc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     out_ready_i,
  input  pc_stat_t stat_i,
  output pc_cmd_t  cmd_o,
  output logic     in_ready_o,
  output logic     out_valid_o
);

  pc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.close)    state_d = S_DIV;
        else if (stat_i.eos) state_d = S_FLUSH;
        else                 state_d = S_IDLE;
      end
      S_FLUSH: begin
        state_d = stat_i.grp_open ? S_DIV : S_EMIT;
      end
      S_DIV: begin
        if (stat_i.div_last) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready_i) begin
          if (!stat_i.res_last && stat_i.eos) state_d = S_FLUSH;
          else                                state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_CHECK: cmd_o.check    = 1'b1;
      S_FLUSH: cmd_o.flush    = 1'b1;
      S_DIV:   cmd_o.div_step = 1'b1;
      S_EMIT:  out_valid_o    = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== design/pc_datapath.sv =====
// ----------------------------------------------------------------------------
// Peak centroiding datapath
// Product register, saturating group sums, gap test and a radix-2 divider.
// ----------------------------------------------------------------------------
module pc_datapath import pc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [0:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  pc_in_t          in_word_i,
  input  pc_cmd_t         cmd_i,
  output pc_stat_t        stat_o,
  output pc_out_t         out_word_o
);

  logic [IntW-1:0]       noise_q;
  logic [MzW-1:0]        gap_q;
  logic [MzW-1:0]        mz_q, prev_q;
  logic [IntW-1:0]       int_q;
  logic                  eos_q, keep_q;
  logic [MzW+IntW-1:0]   prod_q;
  logic [WsumW-1:0]      wsum_q;
  logic [IsumW-1:0]      isum_q;
  logic [WsumW-1:0]      dvd_q, quo_q;
  logic [IsumW-1:0]      dvs_q;
  logic [IsumW:0]        rem_q;
  logic [DivCntW-1:0]    cnt_q;
  logic                  res_last_q;
  pc_out_t               res_q;

  logic                  close;
  logic [MzW-1:0]        diff;
  logic [WsumW-1:0]      wbase;
  logic [IsumW-1:0]      ibase;
  logic [WsumW:0]        wadd;
  logic [IsumW:0]        iadd;
  logic [IsumW:0]        rem_sh, rem_sub;
  logic                  qbit;
  logic [WsumW-1:0]      quo_nx;

  assign diff  = mz_q - prev_q;
  assign close = keep_q && (mz_q > prev_q) && (diff > gap_q) && (wsum_q != '0);
  assign wbase = close ? '0 : wsum_q;
  assign ibase = close ? '0 : isum_q;
  assign wadd  = {1'b0, wbase} + {{(WsumW+1-MzW-IntW){1'b0}}, prod_q};
  assign iadd  = {1'b0, ibase} + {{(IsumW+1-IntW){1'b0}}, int_q};

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh  = {rem_q[IsumW-1:0], dvd_q[WsumW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign qbit    = (rem_sh >= {1'b0, dvs_q});
  assign quo_nx  = {quo_q[WsumW-2:0], qbit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q    <= NoiseFloorRst;
      gap_q      <= GapLimitRst;
      wsum_q     <= '0;
      isum_q     <= '0;
      prev_q     <= '0;
      keep_q     <= 1'b0;
      eos_q      <= 1'b0;
      res_last_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegNoiseFloor: noise_q <= cfg_wdata_i[IntW-1:0];
          RegGapLimit:   gap_q   <= cfg_wdata_i[MzW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.capture) begin
        keep_q <= (in_word_i.peak_intensity >= noise_q);
        eos_q  <= in_word_i.end_of_spectrum;
      end
      if (cmd_i.check) begin
        if (close) res_last_q <= 1'b0;
        if (keep_q) begin
          wsum_q <= wadd[WsumW] ? '1 : wadd[WsumW-1:0];
          isum_q <= iadd[IsumW] ? '1 : iadd[IsumW-1:0];
          prev_q <= mz_q;
        end
      end
      if (cmd_i.flush) begin
        res_last_q <= 1'b1;
        wsum_q     <= '0;
        isum_q     <= '0;
        prev_q     <= '0;
      end
      if (cmd_i.check || cmd_i.flush) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mz_q   <= in_word_i.peak_mz;
      int_q  <= in_word_i.peak_intensity;
      prod_q <= in_word_i.peak_mz * in_word_i.peak_intensity;
    end
    if ((cmd_i.check && close) || cmd_i.flush) begin
      dvd_q <= wsum_q;
      dvs_q <= isum_q;
      rem_q <= '0;
      quo_q <= '0;
      res_q.centroid_intensity <= isum_q;
      res_q.centroid_valid     <= 1'b1;
      res_q.last_result        <= cmd_i.flush;
      res_q.centroid_mz        <= '0;
      if (cmd_i.flush && (wsum_q == '0)) begin
        res_q.centroid_intensity <= '0;
        res_q.centroid_valid     <= 1'b0;
      end
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[WsumW-2:0], 1'b0};
      rem_q <= qbit ? rem_sub : rem_sh;
      quo_q <= quo_nx;
      if (cnt_q == '1) begin
        res_q.centroid_mz <= (quo_nx[WsumW-1:MzW] != '0) ? '1 : quo_nx[MzW-1:0];
      end
    end
  end

  assign stat_o.close    = close;
  assign stat_o.eos      = eos_q;
  assign stat_o.grp_open = (wsum_q != '0);
  assign stat_o.div_last = (cnt_q == '1);
  assign stat_o.res_last = res_last_q;
  assign out_word_o      = res_q;

endmodule

// ===== dv/peak_centroiding_tb.sv =====
// ----------------------------------------------------------------------------
// Peak centroiding testbench
// Streams spectra of peaks into the block, predicts the centroid words from a
// behavioral model of the gap grouping, and checks every output word in order.
// ----------------------------------------------------------------------------
module peak_centroiding_tb;
  import pc_pkg::*;

  localparam int unsigned StallLimit = 20000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [0:0]      cfg_idx_i = RegNoiseFloor;
  logic [CfgW-1:0] cfg_wdata_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  pc_in_t          in_word_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  pc_out_t         out_word_o;

  // Predictor state mirrors the block's group accumulators.
  logic [IntW-1:0]  floor_q = NoiseFloorRst;
  logic [MzW-1:0]   gap_q = GapLimitRst;
  logic [WsumW-1:0] wsum_q = '0;
  logic [IsumW-1:0] isum_q = '0;
  logic [MzW-1:0]   prev_mz_q = '0;

  pc_out_t centroid_queue[$];
  int      errors = 0;
  int      n_words = 0;
  int      n_centroids = 0;
  int      n_peaks = 0;
  int      in_idle_pct = 0;
  int      out_idle_pct = 0;
  int      stall_cycles = 0;

  peak_centroiding uut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [MzW-1:0] group_mean();
    logic [WsumW-1:0] q;
    if (isum_q == 0) return '0;
    q = wsum_q / isum_q;
    return (q > 64'hFFFF_FFFF) ? '1 : q[MzW-1:0];
  endfunction

  function automatic void predict_centroids(pc_in_t w);
    logic [WsumW-1:0] prod;
    logic [IsumW:0]   isum;
    pc_out_t          r;
    if (w.peak_intensity >= floor_q) begin
      if (w.peak_mz > prev_mz_q && (w.peak_mz - prev_mz_q) > gap_q && wsum_q != 0) begin
        r = '{group_mean(), isum_q, 1'b1, 1'b0};
        centroid_queue = {centroid_queue, r};
        wsum_q = '0;
        isum_q = '0;
      end
      prod = 64'(w.peak_mz) * 64'(w.peak_intensity);
      wsum_q = (wsum_q > ~prod) ? '1 : wsum_q + prod;
      isum = {1'b0, isum_q} + w.peak_intensity;
      isum_q = isum[IsumW] ? '1 : isum[IsumW-1:0];
      prev_mz_q = w.peak_mz;
    end
    if (w.end_of_spectrum) begin
      if (wsum_q != 0) r = '{group_mean(), isum_q, 1'b1, 1'b1};
      else r = '{'0, '0, 1'b0, 1'b1};
      centroid_queue = {centroid_queue, r};
      wsum_q = '0;
      isum_q = '0;
      prev_mz_q = '0;
    end
  endfunction

  // Output side: random stalls plus in-order comparison.
  always @(posedge clk_i) begin
    pc_out_t exp_w;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        n_words <= n_words + 1;
        if (out_word_o.centroid_valid) n_centroids <= n_centroids + 1;
        if (centroid_queue.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: unexpected word %h", out_word_o);
        end else begin
          exp_w = centroid_queue.pop_front();
          if (exp_w !== out_word_o) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: word mismatch exp mz=%h int=%h v=%b l=%b got mz=%h int=%h v=%b l=%b",
                       exp_w.centroid_mz, exp_w.centroid_intensity, exp_w.centroid_valid,
                       exp_w.last_result, out_word_o.centroid_mz,
                       out_word_o.centroid_intensity, out_word_o.centroid_valid,
                       out_word_o.last_result);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Valid stays high after a word is taken so that words can follow back to
  // back; an idle cycle or a pause drops it.
  task automatic send_peak(logic [MzW-1:0] mz, logic [IntW-1:0] inten, logic eos);
    pc_in_t w;
    w = '{mz, inten, eos};
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_centroids(w);
    n_peaks++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (centroid_queue.size() != 0) @(posedge clk_i);
    // Let the controller settle back to idle before anything else happens.
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [CfgW-1:0] val);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegNoiseFloor) floor_q = val[IntW-1:0];
    else gap_q = val;
  endtask

  task automatic test_directed();
    // Extremes of m/z and intensity in a single group.
    send_peak('1, '1, 1'b0);
    send_peak('1, '1, 1'b0);
    send_peak('1, '1, 1'b1);
    // Zero-intensity and zero-m/z peaks open no group; bare end marker.
    send_peak(32'h0001_0000, '0, 1'b0);
    send_peak(32'h0, 24'h100, 1'b1);
    // Gap just at and just beyond the limit.
    send_peak(32'h0010_0000, 24'd10, 1'b0);
    send_peak(32'h0010_0000 + GapLimitRst, 24'd20, 1'b0);
    send_peak(32'h0010_0001 + 2 * GapLimitRst, 24'd30, 1'b0);
    // Descending m/z never closes a group.
    send_peak(32'h0001_0000, 24'd5, 1'b1);
    send_peak(32'h0, 24'h0, 1'b1);
    // Dropped final peak still flushes.
    write_reg(RegNoiseFloor, 32'd100);
    send_peak(32'h0020_0000, 24'd500, 1'b0);
    send_peak(32'h0030_0000, 24'd99, 1'b0);
    send_peak(32'h0040_0000, 24'd1, 1'b1);
    write_reg(RegNoiseFloor, 32'hFFFFFF);
    send_peak(32'h0020_0000, 24'hFFFFFE, 1'b0);
    send_peak(32'h0020_0000, 24'hFFFFFF, 1'b1);
    write_reg(RegGapLimit, '1);
    write_reg(RegNoiseFloor, 32'd0);
    send_peak(32'h0000_0001, 24'd1, 1'b0);
    send_peak('1, 24'd1, 1'b1);
    write_reg(RegGapLimit, '0);
    send_peak(32'h0000_0001, 24'd1, 1'b0);
    send_peak(32'h0000_0002, 24'd1, 1'b0);
    send_peak(32'h0000_0002, 24'd1, 1'b1);
  endtask

  task automatic send_spectra(int n_items);
    int sent;
    int len;
    logic [MzW-1:0] mz;
    logic [IntW-1:0] inten;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(12, 1);
      mz = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0100_0000);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(9))
          0: inten = IntW'($urandom);
          1: inten = '0;
          default: inten = IntW'($urandom_range(5000));
        endcase
        if ($urandom_range(15) == 0) mz = $urandom;
        send_peak(mz, inten, i == len - 1);
        sent++;
        // Mostly ascending steps around the gap limit, occasionally backward.
        case ($urandom_range(7))
          0: mz = mz - $urandom_range(4000);
          1, 2: mz = mz + $urandom_range(gap_q > 1000 ? 1000 : gap_q);
          default: mz = mz + $urandom_range(3 * 6554);
        endcase
      end
    end
  endtask

  task automatic test_random();
    in_idle_pct = 30; out_idle_pct = 60;
    write_reg(RegGapLimit, GapLimitRst);
    write_reg(RegNoiseFloor, 32'd0);
    send_spectra(380);
    in_idle_pct = 60; out_idle_pct = 30;
    write_reg(RegNoiseFloor, 32'd1000);
    write_reg(RegGapLimit, 32'd2000);
    send_spectra(380);
    // The sender holds off until every centroid is back.
    wait_drained();
    in_idle_pct = 0; out_idle_pct = 0;
    write_reg(RegNoiseFloor, $urandom_range(3000));
    write_reg(RegGapLimit, $urandom_range(20000));
    send_spectra(380);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    wait_drained();
    $display("Covered %0d peaks giving %0d words, %0d of them centroids.",
             n_peaks, n_words, n_centroids);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
